[sv/lfu_pkg.sv]
// lfu cache table package: sizes, opcodes and request/response types
// no dependencies; used by the front, queue, engine and top-level modules
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CAP_W     = $clog2(NUM_SLOTS) + 1;
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(NUM_SLOTS);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } resp_t;
endpackage
`default_nettype wire

[sv/lfu_front.sv]
// lfu front stage: accepts requests, decodes the operation, pushes to the queue
// depends on lfu_pkg
`timescale 1ns / 1ps
`default_nettype none
module lfu_front (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire                       func,
    input  wire [lfu_pkg::KEY_W-1:0]  lookup_key,
    input  wire [lfu_pkg::DATA_W-1:0] data_in,
    output logic                      push,
    output lfu_pkg::req_t             push_req,
    input  wire                       q_full
);
    logic          hold_vld_reg;
    logic          hold_vld_next;
    lfu_pkg::req_t hold_reg;
    logic          accept;

    assign in_stall = hold_vld_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = hold_vld_reg && !q_full;
    assign push_req = hold_reg;

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        if (push)
        begin
            hold_vld_next = accept;
        end
        else if (accept)
        begin
            hold_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg.op   <= func ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
            hold_reg.key  <= lookup_key;
            hold_reg.data <= data_in;
        end
    end
endmodule
`default_nettype wire

[sv/lfu_queue.sv]
// lfu request queue: two-entry fifo between front and engine
// depends on lfu_pkg
`timescale 1ns / 1ps
`default_nettype none
module lfu_queue (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  lfu_pkg::req_t push_req,
    output logic          full,
    input  wire           pop,
    output lfu_pkg::req_t head,
    output logic          empty
);
    lfu_pkg::req_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end
endmodule
`default_nettype wire

[sv/lfu_engine.sv]
// lfu engine: scans the slots, applies get/put with eviction, holds the result
// depends on lfu_pkg
`timescale 1ns / 1ps
`default_nettype none
module lfu_engine (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire [lfu_pkg::CAP_W-1:0]  cap,
    input  wire                       q_empty,
    input  lfu_pkg::req_t             q_head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire                       out_stall,
    output lfu_pkg::resp_t            resp
);
    localparam int N  = lfu_pkg::NUM_SLOTS;
    localparam int SW = lfu_pkg::SLOT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_APPLY  = 3'd2;
    localparam logic [2:0] ST_INSERT = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]    state_reg;
    logic [SW-1:0] idx_reg;
    lfu_pkg::req_t req_reg;

    logic                        valid_reg [N];
    logic [lfu_pkg::KEY_W-1:0]   key_mem   [N];
    logic [lfu_pkg::DATA_W-1:0]  data_mem  [N];
    logic [lfu_pkg::CNT_W-1:0]   cnt_mem   [N];
    logic [SW-1:0]               rank_mem  [N];
    logic [lfu_pkg::CAP_W-1:0]   live_reg;

    logic                        hit_fnd_reg;
    logic [SW-1:0]               hit_idx_reg;
    logic [lfu_pkg::DATA_W-1:0]  hit_data_reg;
    logic [lfu_pkg::CNT_W-1:0]   hit_cnt_reg;
    logic [SW-1:0]               hit_rank_reg;
    logic                        vic_fnd_reg;
    logic [SW-1:0]               vic_idx_reg;
    logic [lfu_pkg::CNT_W-1:0]   vic_cnt_reg;
    logic [SW-1:0]               vic_rank_reg;
    logic [lfu_pkg::KEY_W-1:0]   vic_key_reg;
    logic                        free_fnd_reg;
    logic [SW-1:0]               free_idx_reg;
    lfu_pkg::resp_t              res_reg;
    logic                        out_vld_reg;
    lfu_pkg::resp_t              out_reg;

    logic                        cur_valid;
    logic [lfu_pkg::KEY_W-1:0]   cur_key;
    logic [lfu_pkg::CNT_W-1:0]   cur_cnt;
    logic [SW-1:0]               cur_rank;
    logic                        key_match;
    logic                        vic_better;
    logic [lfu_pkg::CAP_W-1:0]   cap_eff;
    logic                        do_touch;
    logic                        do_evict;
    logic                        do_insert;
    logic                        out_load;

    assign cur_valid  = valid_reg[idx_reg];
    assign cur_key    = key_mem[idx_reg];
    assign cur_cnt    = cnt_mem[idx_reg];
    assign cur_rank   = rank_mem[idx_reg];
    assign key_match  = cur_valid && (cur_key == req_reg.key);
    assign vic_better = cur_valid && (!vic_fnd_reg || (cur_cnt < vic_cnt_reg) ||
                        ((cur_cnt == vic_cnt_reg) && (cur_rank > vic_rank_reg)));
    assign cap_eff    = (cap > lfu_pkg::CAP_W'(N)) ? lfu_pkg::CAP_W'(N) : cap;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_load  = (state_reg == ST_DONE) && (!out_vld_reg || !out_stall);
    assign out_valid = out_vld_reg;
    assign resp      = out_reg;

    always_comb
    begin
        do_touch = 1'b0;
        do_evict = 1'b0;
        if (state_reg == ST_APPLY && hit_fnd_reg)
        begin
            do_touch = (req_reg.op == lfu_pkg::OP_GET) || (cap_eff != '0);
        end
        if (state_reg == ST_APPLY && !hit_fnd_reg && req_reg.op == lfu_pkg::OP_PUT &&
            cap_eff != '0)
        begin
            do_evict = (live_reg >= cap_eff) && vic_fnd_reg;
        end
        do_insert = (state_reg == ST_INSERT) && free_fnd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            live_reg    <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            if (do_evict)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
                live_reg <= live_reg - 1'b1;
            end
            if (do_insert)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                live_reg <= live_reg + 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == SW'(N - 1))
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    if (req_reg.op == lfu_pkg::OP_PUT && !hit_fnd_reg && cap_eff != '0)
                    begin
                        state_reg <= ST_INSERT;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_INSERT:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
        case (state_reg)
            ST_IDLE:
            begin
                req_reg      <= q_head;
                idx_reg      <= '0;
                hit_fnd_reg  <= 1'b0;
                vic_fnd_reg  <= 1'b0;
                free_fnd_reg <= 1'b0;
                res_reg      <= '0;
            end
            ST_SCAN:
            begin
                idx_reg <= idx_reg + 1'b1;
                if (key_match && !hit_fnd_reg)
                begin
                    hit_fnd_reg  <= 1'b1;
                    hit_idx_reg  <= idx_reg;
                    hit_data_reg <= data_mem[idx_reg];
                    hit_cnt_reg  <= cur_cnt;
                    hit_rank_reg <= cur_rank;
                end
                if (vic_better)
                begin
                    vic_fnd_reg  <= 1'b1;
                    vic_idx_reg  <= idx_reg;
                    vic_cnt_reg  <= cur_cnt;
                    vic_rank_reg <= cur_rank;
                    vic_key_reg  <= cur_key;
                end
                if (!cur_valid && !free_fnd_reg)
                begin
                    free_fnd_reg <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
            end
            ST_APPLY:
            begin
                res_reg.hit <= hit_fnd_reg;
                if (req_reg.op == lfu_pkg::OP_GET)
                begin
                    res_reg.data <= hit_fnd_reg ? hit_data_reg : '1;
                end
                if (do_touch)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (valid_reg[i] && rank_mem[i] < hit_rank_reg)
                        begin
                            rank_mem[i] <= rank_mem[i] + 1'b1;
                        end
                    end
                    rank_mem[hit_idx_reg] <= '0;
                    if (hit_cnt_reg != lfu_pkg::CNT_MAX)
                    begin
                        cnt_mem[hit_idx_reg] <= hit_cnt_reg + 1'b1;
                    end
                    if (req_reg.op == lfu_pkg::OP_PUT)
                    begin
                        data_mem[hit_idx_reg] <= req_reg.data;
                    end
                end
                if (do_evict)
                begin
                    res_reg.evicted     <= 1'b1;
                    res_reg.evicted_key <= vic_key_reg;
                    for (int i = 0; i < N; i++)
                    begin
                        if (valid_reg[i] && rank_mem[i] > vic_rank_reg)
                        begin
                            rank_mem[i] <= rank_mem[i] - 1'b1;
                        end
                    end
                    if (!free_fnd_reg || vic_idx_reg < free_idx_reg)
                    begin
                        free_fnd_reg <= 1'b1;
                        free_idx_reg <= vic_idx_reg;
                    end
                end
            end
            ST_INSERT:
            begin
                if (do_insert)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            rank_mem[i] <= rank_mem[i] + 1'b1;
                        end
                    end
                    rank_mem[free_idx_reg] <= '0;
                    key_mem[free_idx_reg]  <= req_reg.key;
                    data_mem[free_idx_reg] <= req_reg.data;
                    cnt_mem[free_idx_reg]  <= lfu_pkg::CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

[sv/lfu_cache_table_core.sv]
// lfu cache table top level: config register, front stage, queue and engine
// depends on lfu_pkg, lfu_front, lfu_queue, lfu_engine
//
// requests (func, lookup_key, data_in) transfer on in_valid high and in_stall low;
// results (hit, data_out, evicted, evicted_key) transfer on out_valid high and
// out_stall low, exactly one result per request, in request order.
// func 0 is a get, func 1 is a put. capacity_in_use sits at apb address 0. the
// user must write it only while no request is in flight; the block itself does
// not enforce this. a request passes through the front register and the queue
// to the engine, which adds an insert step for a put of a new key with a nonzero
// capacity. the engine works on one request at a time, stepping through the
// sixteen slots one per cycle to find the match, victim and free slot.
// a two-entry queue and the front register keep taking requests while the engine
// works; a stalled result holds in the output register while the engine goes on.
// reset empties the cache, clears the queue and sets capacity_in_use to 16.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_table_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         func,
    input  wire [31:0]  lookup_key,
    input  wire [31:0]  data_in,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        hit,
    output logic [31:0] data_out,
    output logic        evicted,
    output logic [31:0] evicted_key
);
    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic                      push;
    lfu_pkg::req_t             push_req;
    logic                      q_full;
    logic                      pop;
    lfu_pkg::req_t             q_head;
    logic                      q_empty;
    lfu_pkg::resp_t            resp;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(cap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && paddr == 3'd0)
        begin
            cap_reg <= pwdata[lfu_pkg::CAP_W-1:0];
        end
    end

    lfu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .lookup_key (lookup_key),
        .data_in    (data_in),
        .push       (push),
        .push_req   (push_req),
        .q_full     (q_full)
    );

    lfu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    lfu_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .resp      (resp)
    );

    assign hit         = resp.hit;
    assign data_out    = resp.data;
    assign evicted     = resp.evicted;
    assign evicted_key = resp.evicted_key;
endmodule
`default_nettype wire

[sv/lfu_checker.sv]
// lfu port checker: result consistency and output handshake checks
// no dependencies; bound to lfu_cache_table_core
`timescale 1ns / 1ps
`default_nettype none
module lfu_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        out_valid,
    input wire        out_stall,
    input wire        hit,
    input wire [31:0] data_out,
    input wire        evicted,
    input wire [31:0] evicted_key
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit && data_out == 32'd0)
        else $error("eviction reported on a hit or with data");

    a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_key == 32'd0)
        else $error("evicted key set without eviction");

    a_miss_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> data_out == 32'd0 || data_out == 32'hFFFF_FFFF)
        else $error("miss returned stored data");
endmodule

bind lfu_cache_table_core lfu_checker u_lfu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .data_out    (data_out),
    .evicted     (evicted),
    .evicted_key (evicted_key)
);
`default_nettype wire
